FILE: rtl/core/hne_pkg.sv
// Shared types, constants and helper functions of the Hamming neighbor enumerator.
package hne_pkg;

    localparam int DATA_W  = 32;
    localparam int DIST_W  = 6;
    localparam int KEY_W   = 6;
    localparam int QUEUE_D = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic       CMD_NEXT     = 1'b0;
    localparam logic       CMD_RESTART  = 1'b1;
    localparam logic [KEY_W-1:0] KEY_RESET = KEY_W'(DATA_W);

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [DIST_W-1:0] t_dist;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic  restart;
        t_word base;
    } t_entry;

    // Index of the single set bit of a one-hot word (zero for an empty word).
    function automatic t_dist onehot_index(input t_word oh);
        t_dist idx;
        idx = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (oh[i]) begin
                idx = idx | t_dist'(i);
            end
        end
        return idx;
    endfunction

    // Count of trailing zero bits; the lowest set bit is isolated first.
    function automatic t_dist trailing_zeros(input t_word v);
        t_word low_bit;
        low_bit = v & (~v + t_word'(1));
        return onehot_index(low_bit);
    endfunction

endpackage

FILE: rtl/core/hamming_neighbor_enumerator.sv
// Top level of the Hamming neighbor enumerator: front queue and execution back end.
//
// Input channel: i_in_valid / o_in_stall carry i_cmd and i_base_value. A transfer with
// i_cmd = 1 loads a new base and restarts the enumeration without a result. A transfer
// with i_cmd = 0 yields one result: the base XOR the current flip mask and its distance;
// once every mask within the key width has been given, it yields o_done_res instead.
// Output channel: o_out_valid / i_out_stall carry o_neighbor, o_distance, o_done_res.
// Config channel: i_cfg_valid / o_cfg_ready write the key width (ready is always high);
// write it only while no items are in flight.
// An input transfer is written into the queue and its result into the output register.
// One item is taken each cycle while o_in_stall is low; the next-mask step (increment,
// two trailing-zero counts and a shift) is combinational in the back end. A two-entry
// queue decouples input from execution. When the receiver stalls, the result register
// holds, the queue fills and o_in_stall rises once both queue entries are taken.
// Reset (synchronous, active low) empties the queue, clears the output, sets the key
// width to 32 and enumerates around base zero.
module hamming_neighbor_enumerator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [hne_pkg::KEY_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [31:0]               i_base_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [31:0]               o_neighbor,
    output logic [5:0]                o_distance,
    output logic                      o_done_res
);

    logic            w_q_valid;
    hne_pkg::t_entry w_q_entry;
    logic            w_q_pop;

    hne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_base_value (i_base_value),
        .o_q_valid    (w_q_valid),
        .o_q_entry    (w_q_entry),
        .i_q_pop      (w_q_pop)
    );

    hne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_neighbor  (o_neighbor),
        .o_distance  (o_distance),
        .o_done_res  (o_done_res)
    );

endmodule

FILE: rtl/core/hne_front.sv
// Front part: accepts input items, classifies them and holds them in a short queue.
module hne_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  hne_pkg::t_word     i_base_value,
    output logic               o_q_valid,
    output hne_pkg::t_entry    o_q_entry,
    input  logic               i_q_pop
);

    hne_pkg::t_entry                 r_q [hne_pkg::QUEUE_D];
    logic [hne_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [hne_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [hne_pkg::QCNT_W-1:0]      r_count;
    logic [hne_pkg::QCNT_W-1:0]      n_count;
    hne_pkg::t_entry                 w_entry;
    logic                            w_push;
    logic                            w_pop;

    assign o_in_stall = (r_count == hne_pkg::QCNT_W'(hne_pkg::QUEUE_D));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_entry  = r_q[r_rd_ptr];

    always_comb begin
        w_entry.restart = (i_cmd == hne_pkg::CMD_RESTART);
        w_entry.base    = i_base_value;
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + hne_pkg::QCNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - hne_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + hne_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + hne_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

endmodule

FILE: rtl/core/hne_back.sv
// Back part: enumeration state, next-mask step, key width register and output register.
module hne_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [hne_pkg::KEY_W-1:0] i_cfg_data,
    input  logic               i_q_valid,
    input  hne_pkg::t_entry    i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hne_pkg::t_word     o_neighbor,
    output hne_pkg::t_dist     o_distance,
    output logic               o_done_res
);

    logic [hne_pkg::KEY_W-1:0] r_key_bits;
    hne_pkg::t_word            r_base;
    hne_pkg::t_word            r_mask;
    hne_pkg::t_dist            r_dist;
    logic                      r_exhausted;
    logic                      r_out_valid;
    hne_pkg::t_word            r_neighbor;
    hne_pkg::t_dist            r_distance;
    logic                      r_done_res;

    hne_pkg::t_word            n_mask;
    hne_pkg::t_dist            n_dist;
    logic                      n_exhausted;

    logic [hne_pkg::KEY_W-1:0] w_width;
    logic [hne_pkg::DATA_W:0]  w_field;
    logic [hne_pkg::DATA_W:0]  w_t;
    hne_pkg::t_dist            w_tz_t;
    hne_pkg::t_dist            w_tz_v;
    hne_pkg::t_dist            w_shift;
    hne_pkg::t_word            w_next_same;
    logic                      w_level_end;
    logic [hne_pkg::DIST_W:0]  w_next_dist;
    logic [hne_pkg::DATA_W:0]  w_next_low;
    logic                      w_out_free;
    logic                      w_exec;
    logic                      w_emit;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop    = i_q_valid && (i_q_entry.restart || w_out_free);
    assign w_exec     = o_q_pop;
    assign w_emit     = w_exec && !i_q_entry.restart;

    // Key widths beyond the datapath saturate to its width.
    assign w_width = (r_key_bits > hne_pkg::KEY_W'(hne_pkg::DATA_W))
                   ? hne_pkg::KEY_W'(hne_pkg::DATA_W) : r_key_bits;
    assign w_field = ({{hne_pkg::DATA_W{1'b0}}, 1'b1} << w_width) - (hne_pkg::DATA_W+1)'(1);

    // Next permutation of the same popcount: carry the lowest run of ones up by one
    // place and refill its remaining ones at the bottom.
    assign w_t     = {1'b0, r_mask | (r_mask - hne_pkg::t_word'(1))} + (hne_pkg::DATA_W+1)'(1);
    assign w_tz_t  = hne_pkg::trailing_zeros(w_t[hne_pkg::DATA_W-1:0]);
    assign w_tz_v  = hne_pkg::trailing_zeros(r_mask);
    assign w_shift = w_tz_t - w_tz_v - hne_pkg::t_dist'(1);
    assign w_next_same = w_t[hne_pkg::DATA_W-1:0]
                       | ((hne_pkg::t_word'(1) << w_shift[hne_pkg::DIST_W-2:0])
                          - hne_pkg::t_word'(1));

    // A level ends at distance zero (empty mask) or once the carried mask leaves the key field.
    assign w_level_end = (r_mask == '0) || (r_dist == '0)
                       || ((w_t & ~w_field) != '0);

    assign w_next_dist = {1'b0, r_dist} + (hne_pkg::DIST_W+1)'(1);
    assign w_next_low  = ({{hne_pkg::DATA_W{1'b0}}, 1'b1} << w_next_dist)
                       - (hne_pkg::DATA_W+1)'(1);

    always_comb begin
        n_mask      = r_mask;
        n_dist      = r_dist;
        n_exhausted = r_exhausted;
        if (!w_level_end) begin
            n_mask = w_next_same;
        end else if (w_next_dist > (hne_pkg::DIST_W+1)'(w_width)) begin
            n_exhausted = 1'b1;
            n_mask      = '0;
        end else begin
            n_dist = w_next_dist[hne_pkg::DIST_W-1:0];
            n_mask = w_next_low[hne_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits  <= hne_pkg::KEY_RESET;
            r_base      <= '0;
            r_mask      <= '0;
            r_dist      <= '0;
            r_exhausted <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key_bits <= i_cfg_data;
            end
            if (w_exec && i_q_entry.restart) begin
                r_base      <= i_q_entry.base;
                r_mask      <= '0;
                r_dist      <= '0;
                r_exhausted <= 1'b0;
            end else if (w_emit && !r_exhausted) begin
                r_mask      <= n_mask;
                r_dist      <= n_dist;
                r_exhausted <= n_exhausted;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_exhausted) begin
                r_neighbor <= '0;
                r_distance <= '0;
                r_done_res <= 1'b1;
            end else begin
                r_neighbor <= r_base ^ r_mask;
                r_distance <= r_dist;
                r_done_res <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_neighbor  = r_neighbor;
    assign o_distance  = r_distance;
    assign o_done_res  = r_done_res;

endmodule
